// ----- rtl/quadrature_mouse_pulse_emulator_core_defines.svh -----
// ----------------------------------------------------------------------------
// quadrature mouse pulse emulator: assertion macros
// shared assertion shorthands, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef QUADRATURE_MOUSE_PULSE_EMULATOR_CORE_DEFINES_SVH
`define QUADRATURE_MOUSE_PULSE_EMULATOR_CORE_DEFINES_SVH

// same-cycle implication
`define QMPE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define QMPE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/qmpe_pkg.sv -----
// ----------------------------------------------------------------------------
// qmpe_pkg
// types, codes and widths shared by the mouse pulse emulator files
// ----------------------------------------------------------------------------
package qmpe_pkg;

  localparam int KIND_W  = 2;
  localparam int DELTA_W = 12;
  localparam int MAG_W   = 11;   // whole steps per move, up to 1024
  localparam int BTN_W   = 3;
  localparam int ROW_W   = 8;
  localparam int MROW_W  = 4;
  localparam int NDIR    = 4;
  localparam int FIRE_W  = 2;
  localparam int LINES_W = NDIR + FIRE_W;

  localparam int PENDING_CAP_DEF = 32;

  localparam logic [MROW_W-1:0] MOUSE_ROW_RST = 4'd9;
  localparam logic [ROW_W-1:0]  LAST_ROW_RST  = 8'hFF;

  localparam int DIR_UP    = 0;
  localparam int DIR_DOWN  = 1;
  localparam int DIR_LEFT  = 2;
  localparam int DIR_RIGHT = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_MOVE   = 2'd0,
    KIND_BUTTON = 2'd1,
    KIND_ROW    = 2'd2,
    KIND_RESET  = 2'd3
  } kind_t;

endpackage

// ----- rtl/quadrature_mouse_pulse_emulator_core.sv -----
// ----------------------------------------------------------------------------
// quadrature_mouse_pulse_emulator_core
// host mouse events in, emulated mouse lines of one keyboard row out
// ----------------------------------------------------------------------------
//  channel | ports                               | beat
//  --------+-------------------------------------+-----------------------------
//  in      | in_valid / in_ready, in_* fields    | one host event or row read
//  out     | out_valid / out_ready, out_row_lines| one line mask per input beat
//  cfg     | cfg_wr_en, cfg_wr_data              | mouse row, no handshake
//
//  one beat per cycle sustained while out_ready holds; out_valid rises once
//  the beat has passed the input register, then the state update and result
//  register; a stalled result holds in the result register while the input
//  register still takes one more beat; in_ready drops only when both are full
//  rst_n is synchronous; every state register clears in the same cycle
// ----------------------------------------------------------------------------
module quadrature_mouse_pulse_emulator_core import qmpe_pkg::*; #(
  parameter int PENDING_CAP = PENDING_CAP_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [MROW_W-1:0]         cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [KIND_W-1:0]         in_kind,
  input  logic signed [DELTA_W-1:0] in_move_dx,
  input  logic signed [DELTA_W-1:0] in_move_dy,
  input  logic [BTN_W-1:0]          in_button_index,
  input  logic                      in_button_pressed,
  input  logic [ROW_W-1:0]          in_selected_row,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [LINES_W-1:0]        out_row_lines
);

  // pending counter width follows the cap; sums get one extra bit
  localparam int PEND_W = $clog2(PENDING_CAP + 1);
  localparam int SUM_W  = ((PEND_W > MAG_W) ? PEND_W : MAG_W) + 1;
  localparam logic [SUM_W-1:0] CAP_SUM = SUM_W'(PENDING_CAP);

  // configuration
  logic [MROW_W-1:0] mouse_row_r;

  // input register
  logic                      stg_v_r;
  kind_t                     stg_kind_r;
  logic signed [DELTA_W-1:0] stg_dx_r;
  logic signed [DELTA_W-1:0] stg_dy_r;
  logic [BTN_W-1:0]          stg_btn_r;
  logic                      stg_press_r;
  logic [ROW_W-1:0]          stg_row_r;

  // emulator state
  logic signed [1:0]   acc_x_r,  acc_x_nxt;
  logic signed [1:0]   acc_y_r,  acc_y_nxt;
  logic [PEND_W-1:0]   pend_r   [NDIR];
  logic [PEND_W-1:0]   pend_nxt [NDIR];
  logic [NDIR-1:0]     pulsed_r, pulsed_nxt;
  logic [ROW_W-1:0]    last_row_r, last_row_nxt;
  logic [FIRE_W-1:0]   fire_r,   fire_nxt;

  // result register
  logic                out_v_r;
  logic [LINES_W-1:0]  lines_r;

  // axis results
  logic signed [1:0]   ax_acc_nxt, ay_acc_nxt;
  logic [MAG_W-1:0]    ax_mag, ay_mag;
  logic                ax_neg, ay_neg;

  logic [MAG_W-1:0]    add_amt  [NDIR];
  logic [SUM_W-1:0]    pend_sum [NDIR];

  logic out_ld;
  logic was_sel;
  logic is_sel;

  // the stage moves into the result register whenever that register is free
  // or being emptied this cycle
  assign out_ld   = stg_v_r && (!out_v_r || out_ready);
  assign in_ready = !stg_v_r || out_ld;

  assign out_valid     = out_v_r;
  assign out_row_lines = lines_r;

  qmpe_axis u_axis_x (
    .acc      (acc_x_r),
    .delta    (stg_dx_r),
    .acc_nxt  (ax_acc_nxt),
    .step_mag (ax_mag),
    .step_neg (ax_neg)
  );

  qmpe_axis u_axis_y (
    .acc      (acc_y_r),
    .delta    (stg_dy_r),
    .acc_nxt  (ay_acc_nxt),
    .step_mag (ay_mag),
    .step_neg (ay_neg)
  );

  // route whole steps to their direction; the other side of each axis gets zero
  always_comb begin
    add_amt[DIR_RIGHT] = ax_neg ? '0 : ax_mag;
    add_amt[DIR_LEFT]  = ax_neg ? ax_mag : '0;
    add_amt[DIR_DOWN]  = ay_neg ? '0 : ay_mag;
    add_amt[DIR_UP]    = ay_neg ? ay_mag : '0;
    for (int d = 0; d < NDIR; d++) begin
      pend_sum[d] = SUM_W'(pend_r[d]) + SUM_W'(add_amt[d]);
    end
  end

  // row compare always against the current mouse row; the 0xff reset value of
  // last_row can never match a 4-bit row
  assign was_sel = (last_row_r == ROW_W'(mouse_row_r));
  assign is_sel  = (stg_row_r  == ROW_W'(mouse_row_r));

  always_comb begin
    acc_x_nxt    = acc_x_r;
    acc_y_nxt    = acc_y_r;
    pulsed_nxt   = pulsed_r;
    last_row_nxt = last_row_r;
    fire_nxt     = fire_r;
    for (int d = 0; d < NDIR; d++) begin
      pend_nxt[d] = pend_r[d];
    end
    unique case (stg_kind_r)
      KIND_MOVE: begin
        acc_x_nxt = ax_acc_nxt;
        acc_y_nxt = ay_acc_nxt;
        // saturate each counter at the cap
        for (int d = 0; d < NDIR; d++) begin
          pend_nxt[d] = (pend_sum[d] > CAP_SUM) ? PEND_W'(PENDING_CAP)
                                                : pend_sum[d][PEND_W-1:0];
        end
      end
      KIND_BUTTON: begin
        // only buttons 0 and 1 map to fire lines
        if (stg_btn_r[BTN_W-1:1] == '0) begin
          fire_nxt[stg_btn_r[0]] = stg_press_r;
        end
      end
      KIND_ROW: begin
        if (was_sel && !is_sel) begin
          // deselect edge: let go of the pulsed directions
          pulsed_nxt = '0;
        end else if (is_sel && !was_sel) begin
          // select edge: pulse one step per owed direction
          for (int d = 0; d < NDIR; d++) begin
            pulsed_nxt[d] = (pend_r[d] != '0);
            if (pend_r[d] != '0) begin
              pend_nxt[d] = pend_r[d] - PEND_W'(1);
            end
          end
        end
        last_row_nxt = stg_row_r;
      end
      KIND_RESET: begin
        acc_x_nxt    = '0;
        acc_y_nxt    = '0;
        pulsed_nxt   = '0;
        last_row_nxt = LAST_ROW_RST;
        fire_nxt     = '0;
        for (int d = 0; d < NDIR; d++) begin
          pend_nxt[d] = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mouse_row_r <= MOUSE_ROW_RST;
    end else if (cfg_wr_en) begin
      mouse_row_r <= cfg_wr_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else if (in_ready) begin
      stg_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stg_kind_r  <= kind_t'(in_kind);
      stg_dx_r    <= in_move_dx;
      stg_dy_r    <= in_move_dy;
      stg_btn_r   <= in_button_index;
      stg_press_r <= in_button_pressed;
      stg_row_r   <= in_selected_row;
    end
  end

  // state commits together with the result that shows it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_x_r    <= '0;
      acc_y_r    <= '0;
      pulsed_r   <= '0;
      last_row_r <= LAST_ROW_RST;
      fire_r     <= '0;
      for (int d = 0; d < NDIR; d++) begin
        pend_r[d] <= '0;
      end
    end else if (out_ld) begin
      acc_x_r    <= acc_x_nxt;
      acc_y_r    <= acc_y_nxt;
      pulsed_r   <= pulsed_nxt;
      last_row_r <= last_row_nxt;
      fire_r     <= fire_nxt;
      for (int d = 0; d < NDIR; d++) begin
        pend_r[d] <= pend_nxt[d];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_ld) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      lines_r <= {fire_nxt, pulsed_nxt};
    end
  end

endmodule

// ----- rtl/qmpe_axis.sv -----
// ----------------------------------------------------------------------------
// qmpe_axis
// one motion axis: half-step accumulate, whole steps truncated toward zero
// ----------------------------------------------------------------------------
module qmpe_axis import qmpe_pkg::*; (
  input  logic signed [1:0]         acc,
  input  logic signed [DELTA_W-1:0] delta,
  output logic signed [1:0]         acc_nxt,
  output logic [MAG_W-1:0]          step_mag,
  output logic                      step_neg
);

  localparam int SUM_W = DELTA_W + 1;

  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] whole;
  logic signed [SUM_W-1:0] whole_abs;
  logic                    odd;
  logic                    neg;

  always_comb begin
    sum   = SUM_W'(acc) + SUM_W'(delta);
    odd   = sum[0];
    neg   = sum[SUM_W-1];
    // bias negative odd sums up by one so the shift rounds toward zero
    whole = (sum + $signed(SUM_W'({1'b0, neg & odd}))) >>> 1;
    whole_abs = whole[SUM_W-1] ? -whole : whole;
    step_neg  = whole[SUM_W-1];
    step_mag  = whole_abs[MAG_W-1:0];
    // remainder keeps the sign of the sum
    if (!odd) begin
      acc_nxt = 2'sd0;
    end else if (neg) begin
      acc_nxt = -2'sd1;
    end else begin
      acc_nxt = 2'sd1;
    end
  end

endmodule

// ----- rtl/qmpe_checker.sv -----
// ----------------------------------------------------------------------------
// qmpe_checker
// port-level checks on beat flow of the mouse pulse emulator
// ----------------------------------------------------------------------------
`include "quadrature_mouse_pulse_emulator_core_defines.svh"

module qmpe_checker import qmpe_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [LINES_W-1:0] out_row_lines
);

  // beats taken in but not yet delivered
  logic [1:0] inflight_r;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else if (in_acc && !out_acc) begin
      inflight_r <= inflight_r + 2'd1;
    end else if (out_acc && !in_acc) begin
      inflight_r <= inflight_r - 2'd1;
    end
  end

  `QMPE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_row_lines), "stalled result changed")
  `QMPE_ASSERT_NOW(a_inflight_max, 1'b1, inflight_r != 2'd3, "more than two beats in flight")
  `QMPE_ASSERT_NOW(a_out_has_src, out_valid, inflight_r != 2'd0, "result without an input beat")
  `QMPE_ASSERT_NOW(a_stall_cause, !in_ready, out_valid && !out_ready, "input stalled with output free")

endmodule

bind quadrature_mouse_pulse_emulator_core qmpe_checker u_qmpe_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_row_lines (out_row_lines)
);
